// ----- rtl/rccf_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rccf_pkg: shared types and constants of the raised-cosine crossfader
// Holds the frame and mix word types, register indexes, the fixed-point
// constants of the cosine evaluation and the per-term divisor tables.
// ----------------------------------------------------------------------------
package rccf_pkg;

	// Sample width of every audio field.
	localparam int SAMPLE_BITS = 24;

	// Width of the shared signed multiplier operands.
	localparam int MUL_W = 33;

	// Quotient bits of the phase division (Q0.32 phase).
	localparam int QUOT_BITS = 32;

	// Pi and one in Q2.30.
	localparam logic [31:0] PI_Q30  = 32'd3373259426;
	localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

	// Number of Horner terms of the cosine series.
	localparam int TERMS = 6;

	// Configuration register indexes.
	localparam logic [1:0] REG_FADE_LENGTH   = 2'd0;
	localparam logic [1:0] REG_CHANNEL_COUNT = 2'd1;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;

	typedef struct packed {
		sample_t dest_left;
		sample_t dest_right;
		sample_t src_left;
		sample_t src_right;
	} frame_t;

	typedef struct packed {
		sample_t mixed_left;
		sample_t mixed_right;
		logic    fade_last;
	} mix_t;

	// Divisor 2k(2k-1) of the Horner step, term index 0 is k = 6.
	function automatic logic [7:0] term_div(input logic [2:0] idx);
		logic [7:0] d;
		unique case (idx)
			3'd0: d = 8'd132;
			3'd1: d = 8'd90;
			3'd2: d = 8'd56;
			3'd3: d = 8'd30;
			3'd4: d = 8'd12;
			3'd5: d = 8'd2;
			default: d = 8'd2;
		endcase
		return d;
	endfunction

	// Reciprocal floor(2^32 / divisor) used for the estimate quotient.
	function automatic logic [31:0] term_recip(input logic [2:0] idx);
		logic [31:0] m;
		unique case (idx)
			3'd0: m = 32'd32537631;
			3'd1: m = 32'd47721858;
			3'd2: m = 32'd76695844;
			3'd3: m = 32'd143165576;
			3'd4: m = 32'd357913941;
			3'd5: m = 32'd2147483648;
			default: m = 32'd2147483648;
		endcase
		return m;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/raised_cosine_crossfader_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// raised_cosine_crossfader_unit: raised-cosine crossfade of one frame pair
// Blends a fading-out and a fading-in frame with a cosine weight that
// follows a fade position counter, one frame at a time.
// ----------------------------------------------------------------------------
// Usage:
// A frame word (destination and source samples, left and right) enters on
// frame_valid/frame_stall; the blended mix word leaves on mix_valid/mix_stall
// with fade_last set on the final frame of each fade window. Registers are
// written on cfg_valid/cfg_ready: index 0 is the fade length, index 1 the
// channel count. Write them only while no frame is in flight.
// One frame passes from acceptance to mix_valid through a one-bit-per-cycle
// restoring divider for the phase, then a sequencer that runs the cosine
// series and the two channel blends through one shared 33x33 multiplier,
// then the finishing states S_FIN and S_OUT. The next frame is accepted in
// the cycle after the result moves to the output register, so a new frame
// is not taken before the last one is through.
// If the receiver stalls, the finished word waits in the sequencer until the
// output register is free; frame_stall stays high meanwhile.
// Reset sets the fade length to 1, stereo operation and fade position 0.
// ----------------------------------------------------------------------------
module raised_cosine_crossfader_unit
	import rccf_pkg::*;
#(
	parameter int WEIGHT_FRAC_BITS = 16
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       frame_valid,
	output logic            frame_stall,
	input  wire frame_t     frame_word,
	output logic            mix_valid,
	input  wire logic       mix_stall,
	output mix_t            mix_word,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [1:0] cfg_index,
	input  wire logic [15:0] cfg_data
);

	localparam int W      = WEIGHT_FRAC_BITS;
	localparam int F_W    = W + 1;
	localparam int NUM_W  = SAMPLE_BITS + W + 3;
	localparam int CNT_W  = $clog2(QUOT_BITS);
	localparam int TERM_W = 3;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DIV,
		S_ANGLE,
		S_SQUARE,
		S_A2,
		S_POLY_MUL,
		S_RECIP,
		S_BACK,
		S_CORR,
		S_WEIGHT,
		S_MIX_L,
		S_MIX_R,
		S_FIN,
		S_OUT
	} state_t;

	state_t state_q;

	logic [15:0]        fade_length_q;
	logic [1:0]         channel_count_q;
	logic [15:0]        fade_pos_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [TERM_W-1:0]  term_q;

	frame_t             frame_q;
	logic               last_q;
	logic [16:0]        rem_q;
	logic [16:0]        den_q;
	logic [QUOT_BITS-1:0] quot_q;
	logic               upper_q;
	logic [31:0]        a2_q;
	logic [31:0]        p_q;
	logic [31:0]        q0_q;
	logic signed [32:0] c_q;
	logic [F_W-1:0]     f_q;
	sample_t            left_q;
	sample_t            right_q;
	logic signed [2*MUL_W-1:0] prod_q;
	mix_t               mix_q;
	logic               mix_valid_q;

	logic               frame_take;
	logic               out_free;
	logic [15:0]        eff_len;
	logic [15:0]        eff_pos;
	logic               eff_last;

	// Effective window and position: zero length acts as one, a position past
	// a lowered window restarts at zero.
	always_comb begin
		eff_len  = (fade_length_q == 16'd0) ? 16'd1 : fade_length_q;
		eff_pos  = (fade_pos_q >= eff_len) ? 16'd0 : fade_pos_q;
		eff_last = (eff_pos == eff_len - 16'd1);
	end

	assign frame_stall = (state_q != S_IDLE);
	assign frame_take  = frame_valid && !frame_stall;
	assign out_free    = !mix_valid_q || !mix_stall;
	assign cfg_ready   = 1'b1;
	assign mix_valid   = mix_valid_q;
	assign mix_word    = mix_q;

	// Restoring divider step: one quotient bit of (2*pos+1)*2^32 / (2*len).
	logic [17:0] rem_dbl;
	logic        rem_ge;
	logic [16:0] rem_next;

	always_comb begin
		rem_dbl  = {rem_q, 1'b0};
		rem_ge   = (rem_dbl >= {1'b0, den_q});
		rem_next = rem_ge ? 17'(rem_dbl - {1'b0, den_q}) : rem_dbl[16:0];
	end

	// Values taken off the product register in the cosine sequence.
	logic [31:0] u_val;
	logic [31:0] a_val;
	logic [31:0] shr30_val;
	logic [31:0] q0_val;
	logic [7:0]  div_val;
	logic [31:0] r_val;
	logic [31:0] q_fix;
	logic signed [32:0] c_new;

	always_comb begin
		u_val     = quot_q[QUOT_BITS-1] ? (32'd0 - quot_q) : quot_q;
		a_val     = prod_q[63:32];
		shr30_val = prod_q[61:30];
		q0_val    = prod_q[63:32];
		div_val   = term_div(term_q);
		r_val     = p_q - prod_q[31:0];
		q_fix     = q0_q + ((r_val >= {24'd0, div_val}) ? 32'd1 : 32'd0);
		c_new     = $signed({1'b0, ONE_Q30}) - $signed({1'b0, q_fix});
	end

	// Weight from the clamped cosine: f = (g + 2^(30-W)) >> (31-W).
	logic [31:0] c_clamp;
	logic [31:0] g_val;
	logic [31:0] g_rnd;
	logic [31:0] f_full;

	always_comb begin
		if (c_q[32]) begin
			c_clamp = 32'd0;
		end else if (c_q > $signed({1'b0, ONE_Q30})) begin
			c_clamp = ONE_Q30;
		end else begin
			c_clamp = c_q[31:0];
		end
		g_val  = upper_q ? (ONE_Q30 - c_clamp) : (ONE_Q30 + c_clamp);
		g_rnd  = g_val + (32'd1 << (30 - W));
		f_full = g_rnd >> (31 - W);
	end

	// Channel differences for dest*f + src*(2^W - f) = src*2^W + (dest-src)*f.
	logic signed [SAMPLE_BITS:0] diff_left;
	logic signed [SAMPLE_BITS:0] diff_right;

	always_comb begin
		diff_left  = {frame_q.dest_left[SAMPLE_BITS-1], frame_q.dest_left}
		           - {frame_q.src_left[SAMPLE_BITS-1], frame_q.src_left};
		diff_right = {frame_q.dest_right[SAMPLE_BITS-1], frame_q.dest_right}
		           - {frame_q.src_right[SAMPLE_BITS-1], frame_q.src_right};
	end

	// Shared multiplier operand selection.
	logic signed [MUL_W-1:0] mul_a;
	logic signed [MUL_W-1:0] mul_b;

	always_comb begin
		unique case (state_q)
			S_ANGLE: begin
				mul_a = {1'b0, u_val};
				mul_b = {1'b0, PI_Q30};
			end
			S_SQUARE: begin
				mul_a = {1'b0, a_val};
				mul_b = {1'b0, a_val};
			end
			S_POLY_MUL: begin
				mul_a = {1'b0, a2_q};
				mul_b = {2'b00, c_q[30:0]};
			end
			S_RECIP: begin
				mul_a = {1'b0, shr30_val};
				mul_b = {1'b0, term_recip(term_q)};
			end
			S_BACK: begin
				mul_a = {1'b0, q0_val};
				mul_b = {{(MUL_W-8){1'b0}}, div_val};
			end
			S_MIX_L: begin
				mul_a = {{(MUL_W-SAMPLE_BITS-1){diff_left[SAMPLE_BITS]}}, diff_left};
				mul_b = {{(MUL_W-F_W){1'b0}}, f_q};
			end
			S_MIX_R: begin
				mul_a = {{(MUL_W-SAMPLE_BITS-1){diff_right[SAMPLE_BITS]}}, diff_right};
				mul_b = {{(MUL_W-F_W){1'b0}}, f_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Blend finish: add src*2^W, truncate toward zero, drop the W fraction bits.
	sample_t                 mix_src;
	logic signed [NUM_W-1:0] num_base;
	logic signed [NUM_W-1:0] num_sum;
	logic signed [NUM_W-1:0] num_adj;
	sample_t                 mix_res;

	always_comb begin
		mix_src  = (state_q == S_FIN) ? frame_q.src_right : frame_q.src_left;
		num_base = {{3{mix_src[SAMPLE_BITS-1]}}, mix_src, {W{1'b0}}};
		num_sum  = num_base + prod_q[NUM_W-1:0];
		num_adj  = num_sum + (num_sum[NUM_W-1] ? NUM_W'((1 << W) - 1) : NUM_W'(0));
		mix_res  = num_adj[W+SAMPLE_BITS-1:W];
	end

	// Sequencer, registers and the output word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			fade_length_q   <= 16'd1;
			channel_count_q <= 2'd2;
			fade_pos_q      <= 16'd0;
			cnt_q           <= '0;
			term_q          <= '0;
			mix_valid_q     <= 1'b0;
			mix_q           <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_FADE_LENGTH) begin
					fade_length_q <= cfg_data;
				end else if (cfg_index == REG_CHANNEL_COUNT) begin
					channel_count_q <= cfg_data[1:0];
				end
			end
			// The output word is loaded when the result moves out and
			// released once the receiver takes it.
			if ((state_q == S_OUT) && out_free) begin
				mix_valid_q       <= 1'b1;
				mix_q.mixed_left  <= left_q;
				mix_q.mixed_right <= right_q;
				mix_q.fade_last   <= last_q;
			end else if (mix_valid_q && !mix_stall) begin
				mix_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (frame_take) begin
						fade_pos_q <= eff_last ? 16'd0 : 16'(eff_pos + 16'd1);
						cnt_q      <= CNT_W'(QUOT_BITS - 1);
						state_q    <= S_DIV;
					end
				end
				S_DIV: begin
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == '0) begin
						state_q <= S_ANGLE;
					end
				end
				S_ANGLE:    state_q <= S_SQUARE;
				S_SQUARE:   state_q <= S_A2;
				S_A2: begin
					term_q  <= '0;
					state_q <= S_POLY_MUL;
				end
				S_POLY_MUL: state_q <= S_RECIP;
				S_RECIP:    state_q <= S_BACK;
				S_BACK:     state_q <= S_CORR;
				S_CORR: begin
					if (term_q == TERM_W'(TERMS - 1)) begin
						state_q <= S_WEIGHT;
					end else begin
						term_q  <= term_q + TERM_W'(1);
						state_q <= S_POLY_MUL;
					end
				end
				S_WEIGHT:   state_q <= S_MIX_L;
				S_MIX_L:    state_q <= S_MIX_R;
				S_MIX_R:    state_q <= S_FIN;
				S_FIN:      state_q <= S_OUT;
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default:    state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		unique case (state_q)
			S_IDLE: begin
				if (frame_take) begin
					frame_q <= frame_word;
					last_q  <= eff_last;
					rem_q   <= {eff_pos, 1'b1};
					den_q   <= {eff_len, 1'b0};
				end
			end
			S_DIV: begin
				rem_q  <= rem_next;
				quot_q <= {quot_q[QUOT_BITS-2:0], rem_ge};
			end
			S_ANGLE:  upper_q <= quot_q[QUOT_BITS-1];
			S_A2: begin
				a2_q <= shr30_val;
				c_q  <= $signed({1'b0, ONE_Q30});
			end
			S_RECIP:  p_q <= shr30_val;
			S_BACK:   q0_q <= q0_val;
			S_CORR:   c_q <= c_new;
			S_WEIGHT: f_q <= f_full[F_W-1:0];
			S_MIX_R:  left_q <= mix_res;
			S_FIN:    right_q <= channel_count_q[1] ? mix_res : '0;
			default: begin
			end
		endcase
	end

`ifndef SYNTHESIS
	// An accepted frame keeps the input closed in the following cycle.
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		frame_take |=> frame_stall)
		else $error("frame input not closed after accepting a word");

	// The division remainder always stays below the divisor.
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (rem_q < den_q))
		else $error("phase divider remainder out of range");

	// The weight never exceeds one in Q1.W.
	a_weight_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MIX_L) |-> (f_q <= F_W'(1 << W)))
		else $error("crossfade weight above one");

	// A new result word only appears out of the handoff state.
	a_out_from_handoff: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(mix_valid_q) |-> ($past(state_q) == S_OUT))
		else $error("mix word raised outside the handoff state");

	// In mono the right channel of every result is zero.
	a_mono_right_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(mix_valid_q && !channel_count_q[1]) |-> (mix_q.mixed_right == '0))
		else $error("right channel not zero in mono");
`endif

endmodule
`default_nettype wire
